FILE: rtl/core/rrr_pkg.sv
// Shared types and constants for the replica read router.
// Used by the replica cell, the top level, both checkers and the testbench; no dependencies.
package rrr_pkg;

    localparam logic [2:0] OP_ROUTE  = 3'd0;
    localparam logic [2:0] OP_ADD    = 3'd1;
    localparam logic [2:0] OP_REMOVE = 3'd2;
    localparam logic [2:0] OP_UPDATE = 3'd3;
    localparam logic [2:0] OP_LEADER = 3'd4;

    localparam logic [1:0] POL_LEADER = 2'd0;
    localparam logic [1:0] POL_RROBIN = 2'd1;
    localparam logic [1:0] POL_LEAST  = 2'd2;
    localparam logic [1:0] POL_RANDOM = 2'd3;

    localparam logic [7:0] CFG_READ_POLICY  = 8'd0;
    localparam logic [7:0] CFG_MAX_READ_LAG = 8'd1;

    localparam logic [31:0] HASH_MULT = 32'd2654435761;

    typedef struct packed {
        logic [15:0] key;
        logic        linked;
        logic        streaming;
        logic        attached;
        logic [63:0] position;
    } entry_t;

    typedef struct packed {
        logic load_new;
        logic load_upd;
        logic shift;
    } cell_ctrl_t;

endpackage

FILE: rtl/core/rrr_cell.sv
// One table slot: holds a replica entry and judges its own read eligibility.
// Depends on rrr_pkg; loads from its upper neighbour when the table compacts.
module rrr_cell
    import rrr_pkg::*;
(
    input  logic        clk,
    input  cell_ctrl_t  ctrl,
    input  entry_t      neighbour,
    input  logic [15:0] new_key,
    input  logic        new_linked,
    input  logic        new_streaming,
    input  logic        new_attached,
    input  logic [63:0] new_position,
    input  logic [63:0] leader_pos,
    input  logic [63:0] max_lag,
    output entry_t      entry,
    output logic        key_match,
    output logic        eligible,
    output logic [63:0] lag
);

    entry_t entry_reg;
    entry_t entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.shift)
        begin
            entry_next = neighbour;
        end
        else if (ctrl.load_new)
        begin
            entry_next.key       = new_key;
            entry_next.linked    = 1'b0;
            entry_next.streaming = 1'b0;
            entry_next.attached  = 1'b0;
            entry_next.position  = 64'd0;
        end
        else if (ctrl.load_upd)
        begin
            entry_next.linked    = new_linked;
            entry_next.streaming = new_streaming;
            entry_next.attached  = new_attached;
            entry_next.position  = new_position;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry     = entry_reg;
    assign key_match = (entry_reg.key == new_key);
    assign lag       = (leader_pos > entry_reg.position) ? leader_pos - entry_reg.position
                                                         : 64'd0;
    assign eligible  = entry_reg.linked && entry_reg.streaming && entry_reg.attached
                       && ((max_lag == 64'd0) || (lag <= max_lag));

endmodule

FILE: rtl/core/replica_read_router_top.sv
// Top level of the replica read router: a row of rrr_cell slots and the
// sequencer that scans them for routing. Depends on rrr_pkg and rrr_cell.
//
// Channel   Direction  Handshake              Payload
// request   in         start high, busy low   operation, node_key, flags, positions, time
// result    out        done strobe, 1 cycle   failed, to_leader, chosen_key, chosen_slot
// config    in         cfg_valid & cfg_ready  cfg_index, cfg_data
//
// Add, remove, update, set leader, leader-only routes and routes on an empty
// table give their result the cycle after the request. A route under another
// policy scans the entries one slot a cycle, then least lag answers; round robin
// and random add a bit-serial remainder and a second scan to the chosen entry.
// Reset is asynchronous and clears the count, leader position and policy registers.
// The receiver cannot stall; busy holds requests and configuration writes off
// while a route is running.
module replica_read_router_top
    import rrr_pkg::*;
#(
    parameter int SLOTS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  operation,
    input  logic [15:0] node_key,
    input  logic        link_up,
    input  logic        is_streaming,
    input  logic        attached,
    input  logic [63:0] replica_position,
    input  logic [63:0] leader_position,
    input  logic [31:0] time_seconds,
    output logic        done,
    output logic        failed,
    output logic        to_leader,
    output logic [15:0] chosen_key,
    output logic [3:0]  chosen_slot,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DIV, S_SEL} state_t;

    state_t        state_reg;
    logic [CW-1:0] count_reg;
    logic [63:0]   leader_reg;
    logic [63:0]   rotation_reg;
    logic [1:0]    policy_reg;
    logic [63:0]   max_lag_reg;
    logic [IW-1:0] idx_reg;
    logic [CW-1:0] elig_cnt_reg;
    logic [63:0]   best_reg;
    logic [IW-1:0] pick_reg;
    logic [63:0]   dividend_reg;
    logic [CW-1:0] rem_reg;
    logic [5:0]    bit_cnt_reg;
    logic          done_reg;
    logic          failed_reg;
    logic          to_leader_reg;
    logic [15:0]   key_reg;
    logic [3:0]    slot_reg;

    entry_t        cell_q [SLOTS];
    entry_t        chain_in [SLOTS];
    cell_ctrl_t    ctrl [SLOTS];
    logic [63:0]   lag [SLOTS];
    logic [SLOTS-1:0] raw_match;
    logic [SLOTS-1:0] hit;
    logic [SLOTS-1:0] elig;
    logic [IW-1:0] hit_idx;
    logic          any_hit;
    logic          accept;
    logic          full;
    logic [63:0]   hash_prod;
    logic          cur_elig;
    logic [63:0]   cur_lag;
    logic          last_idx;
    logic [CW:0]   rem_shift;
    logic [CW:0]   rem_sub;
    logic [CW-1:0] rem_next;

    assign accept    = start && !busy;
    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = !busy;
    assign full      = (count_reg >= CW'(SLOTS));
    assign hash_prod = time_seconds * HASH_MULT;
    assign cur_elig  = elig[idx_reg];
    assign cur_lag   = lag[idx_reg];
    assign last_idx  = (CW'(idx_reg) + CW'(1)) == count_reg;
    assign rem_shift = {rem_reg, dividend_reg[63]};
    assign rem_sub   = rem_shift - {1'b0, elig_cnt_reg};
    assign rem_next  = (rem_shift >= {1'b0, elig_cnt_reg}) ? rem_sub[CW-1:0]
                                                           : rem_shift[CW-1:0];

    for (genvar i = 0; i < SLOTS; i++)
    begin : g_cell
        if (i + 1 < SLOTS)
        begin : g_mid
            assign chain_in[i] = cell_q[i + 1];
        end
        else
        begin : g_end
            assign chain_in[i] = cell_q[i];
        end

        assign hit[i] = raw_match[i] && (CW'(i) < count_reg);

        assign ctrl[i].load_new = accept && (operation == OP_ADD) && !full && !any_hit
                                  && (count_reg == CW'(i));
        assign ctrl[i].load_upd = accept && (operation == OP_UPDATE) && hit[i];
        assign ctrl[i].shift    = accept && (operation == OP_REMOVE) && any_hit
                                  && (IW'(i) >= hit_idx);

        rrr_cell u_cell (
            .clk           (clk),
            .ctrl          (ctrl[i]),
            .neighbour     (chain_in[i]),
            .new_key       (node_key),
            .new_linked    (link_up),
            .new_streaming (is_streaming),
            .new_attached  (attached),
            .new_position  (replica_position),
            .leader_pos    (leader_reg),
            .max_lag       (max_lag_reg),
            .entry         (cell_q[i]),
            .key_match     (raw_match[i]),
            .eligible      (elig[i]),
            .lag           (lag[i])
        );
    end

    // Keys in the table are unique, so at most one slot matches.
    always_comb
    begin
        hit_idx = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (hit[i])
            begin
                hit_idx = hit_idx | IW'(i);
            end
        end
    end
    assign any_hit = |hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            leader_reg    <= 64'd0;
            rotation_reg  <= 64'd0;
            policy_reg    <= POL_LEADER;
            max_lag_reg   <= 64'd0;
            idx_reg       <= '0;
            elig_cnt_reg  <= '0;
            best_reg      <= '1;
            pick_reg      <= '0;
            dividend_reg  <= 64'd0;
            rem_reg       <= '0;
            bit_cnt_reg   <= 6'd0;
            done_reg      <= 1'b0;
            failed_reg    <= 1'b0;
            to_leader_reg <= 1'b0;
            key_reg       <= 16'd0;
            slot_reg      <= 4'd0;
        end
        else
        begin
            done_reg      <= 1'b0;
            failed_reg    <= 1'b0;
            to_leader_reg <= 1'b0;
            key_reg       <= 16'd0;
            slot_reg      <= 4'd0;

            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_READ_POLICY)
                begin
                    policy_reg   <= cfg_data[1:0];
                    rotation_reg <= 64'd0;
                end
                else if (cfg_index == CFG_MAX_READ_LAG)
                begin
                    max_lag_reg <= cfg_data;
                end
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        case (operation)
                            OP_ROUTE:
                            begin
                                if ((policy_reg == POL_LEADER) || (count_reg == '0))
                                begin
                                    done_reg      <= 1'b1;
                                    to_leader_reg <= 1'b1;
                                end
                                else
                                begin
                                    state_reg    <= S_SCAN;
                                    idx_reg      <= '0;
                                    elig_cnt_reg <= '0;
                                    best_reg     <= '1;
                                    pick_reg     <= '0;
                                    dividend_reg <= (policy_reg == POL_RROBIN) ? rotation_reg
                                                                               : hash_prod;
                                end
                            end
                            OP_ADD:
                            begin
                                done_reg <= 1'b1;
                                if (full || any_hit)
                                begin
                                    failed_reg <= 1'b1;
                                end
                                else
                                begin
                                    count_reg <= count_reg + CW'(1);
                                end
                            end
                            OP_REMOVE, OP_UPDATE:
                            begin
                                done_reg <= 1'b1;
                                if (!any_hit)
                                begin
                                    failed_reg <= 1'b1;
                                end
                                else if (operation == OP_REMOVE)
                                begin
                                    count_reg <= count_reg - CW'(1);
                                end
                            end
                            OP_LEADER:
                            begin
                                done_reg   <= 1'b1;
                                leader_reg <= leader_position;
                            end
                            default:
                            begin
                                done_reg <= 1'b1;
                            end
                        endcase
                    end
                end

                S_SCAN:
                begin
                    // The first eligible entry is always taken, even at the largest lag.
                    if (cur_elig)
                    begin
                        elig_cnt_reg <= elig_cnt_reg + CW'(1);
                        if ((elig_cnt_reg == '0) || (cur_lag < best_reg))
                        begin
                            best_reg <= cur_lag;
                            pick_reg <= idx_reg;
                        end
                    end
                    idx_reg <= idx_reg + IW'(1);
                    if (last_idx)
                    begin
                        if ((elig_cnt_reg == '0) && !cur_elig)
                        begin
                            state_reg     <= S_IDLE;
                            done_reg      <= 1'b1;
                            to_leader_reg <= 1'b1;
                        end
                        else if (policy_reg == POL_LEAST)
                        begin
                            state_reg <= S_IDLE;
                            done_reg  <= 1'b1;
                            if (cur_elig && ((elig_cnt_reg == '0) || (cur_lag < best_reg)))
                            begin
                                key_reg  <= cell_q[idx_reg].key;
                                slot_reg <= 4'(idx_reg);
                            end
                            else
                            begin
                                key_reg  <= cell_q[pick_reg].key;
                                slot_reg <= 4'(pick_reg);
                            end
                        end
                        else
                        begin
                            state_reg   <= S_DIV;
                            rem_reg     <= '0;
                            bit_cnt_reg <= 6'd0;
                        end
                    end
                end

                S_DIV:
                begin
                    // One remainder bit per cycle, most significant dividend bit first.
                    rem_reg      <= rem_next;
                    dividend_reg <= {dividend_reg[62:0], 1'b0};
                    bit_cnt_reg  <= bit_cnt_reg + 6'd1;
                    if (bit_cnt_reg == 6'd63)
                    begin
                        state_reg <= S_SEL;
                        idx_reg   <= '0;
                    end
                end

                S_SEL:
                begin
                    idx_reg <= idx_reg + IW'(1);
                    if (cur_elig)
                    begin
                        if (rem_reg == '0)
                        begin
                            state_reg <= S_IDLE;
                            done_reg  <= 1'b1;
                            key_reg   <= cell_q[idx_reg].key;
                            slot_reg  <= 4'(idx_reg);
                            if (policy_reg == POL_RROBIN)
                            begin
                                rotation_reg <= rotation_reg + 64'd1;
                            end
                        end
                        else
                        begin
                            rem_reg <= rem_reg - CW'(1);
                        end
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign done        = done_reg;
    assign failed      = failed_reg;
    assign to_leader   = to_leader_reg;
    assign chosen_key  = key_reg;
    assign chosen_slot = slot_reg;

endmodule

FILE: rtl/core/rrr_checker.sv
// Port-level checks for the replica read router, bound to the top level.
// Depends on rrr_pkg for the operation codes.
module rrr_port_checks
    import rrr_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic [2:0]  operation,
    input logic        done,
    input logic        failed,
    input logic        to_leader,
    input logic [15:0] chosen_key,
    input logic [3:0]  chosen_slot
);

    // A table request other than a route answers in the very next cycle.
    a_table_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (operation != OP_ROUTE)) |=> done)
        else $error("table request gave no result in the next cycle");

    // A request sent to the leader names no replica.
    a_leader_clean: assert property (@(posedge clk) disable iff (!rst_n)
        to_leader |-> ((chosen_key == 16'd0) && (chosen_slot == 4'd0)))
        else $error("leader result carries a replica");

    // Failure and routing outcome never appear together.
    a_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(failed && to_leader))
        else $error("failed and to_leader both set");

    // Result fields stay cleared outside the strobe.
    a_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !done |-> (!failed && !to_leader && (chosen_key == 16'd0) && (chosen_slot == 4'd0)))
        else $error("result fields active without strobe");

endmodule

bind replica_read_router_top rrr_port_checks u_rrr_port_checks (.*);

FILE: verif/rrr_checker.sv
// Checker for the replica read router: watches request, config and result ports,
// predicts each result from its own copy of the table, and counts mismatches.
// Depends on rrr_pkg.
`timescale 1ns / 1ps

module rrr_checker
    import rrr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [2:0]  operation,
    input  logic [15:0] node_key,
    input  logic        link_up,
    input  logic        is_streaming,
    input  logic        attached,
    input  logic [63:0] replica_position,
    input  logic [63:0] leader_position,
    input  logic [31:0] time_seconds,
    input  logic        done,
    input  logic        failed,
    input  logic        to_leader,
    input  logic [15:0] chosen_key,
    input  logic [3:0]  chosen_slot,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [63:0] cfg_data,
    output int          fail_count,
    output int          pending
);

    localparam int NSLOT = 16;

    typedef struct packed {
        logic        failed;
        logic        to_leader;
        logic [15:0] key;
        logic [3:0]  slot;
    } answer_t;

    entry_t      table_q [NSLOT];
    int          count_q;
    logic [63:0] leader_q;
    logic [63:0] rotation_q;
    logic [1:0]  policy_q;
    logic [63:0] lag_limit_q;
    answer_t     answers_q [$];

    assign pending = answers_q.size();

    function automatic logic [63:0] lag_at(int i);
        return (leader_q > table_q[i].position) ? leader_q - table_q[i].position : 64'd0;
    endfunction

    function automatic int slot_of(logic [15:0] key);
        for (int i = 0; i < count_q; i++)
            if (table_q[i].key == key)
                return i;
        return -1;
    endfunction

    function automatic answer_t apply_request(logic [2:0] op, logic [15:0] key,
                                              logic lk, logic st, logic at,
                                              logic [63:0] rpos, logic [63:0] lpos,
                                              logic [31:0] tsec);
        answer_t     a;
        int          elig [$];
        int          s;
        int          pick;
        logic [63:0] best;
        logic [63:0] h;
        a = '0;
        case (op)
            OP_ROUTE: begin
                if (policy_q != POL_LEADER)
                    for (int i = 0; i < count_q; i++)
                        if (table_q[i].linked && table_q[i].streaming && table_q[i].attached
                            && (lag_limit_q == 0 || lag_at(i) <= lag_limit_q))
                            elig.push_back(i);
                if (elig.size() == 0)
                    a.to_leader = 1'b1;
                else
                begin
                    if (policy_q == POL_RROBIN)
                    begin
                        s = elig[rotation_q % elig.size()];
                        rotation_q++;
                    end
                    else if (policy_q == POL_LEAST)
                    begin
                        best = '1;
                        pick = 0;
                        for (int i = 0; i < elig.size(); i++)
                            if (lag_at(elig[i]) < best)
                            begin
                                best = lag_at(elig[i]);
                                pick = i;
                            end
                        // A lone entry at the largest lag still wins by default.
                        s = elig[pick];
                    end
                    else
                    begin
                        h = 64'(tsec) * 64'(HASH_MULT);
                        s = elig[h % elig.size()];
                    end
                    a.key  = table_q[s].key;
                    a.slot = s[3:0];
                end
            end
            OP_ADD: begin
                if (count_q >= NSLOT || slot_of(key) >= 0)
                    a.failed = 1'b1;
                else
                begin
                    table_q[count_q] = '{key: key, default: '0};
                    count_q++;
                end
            end
            OP_REMOVE: begin
                s = slot_of(key);
                if (s < 0)
                    a.failed = 1'b1;
                else
                begin
                    for (int i = s; i + 1 < count_q; i++)
                        table_q[i] = table_q[i + 1];
                    count_q--;
                end
            end
            OP_UPDATE: begin
                s = slot_of(key);
                if (s < 0)
                    a.failed = 1'b1;
                else
                begin
                    table_q[s].linked    = lk;
                    table_q[s].streaming = st;
                    table_q[s].attached  = at;
                    table_q[s].position  = rpos;
                end
            end
            OP_LEADER: leader_q = lpos;
            default: ;
        endcase
        return a;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        answer_t got;
        answer_t want;
        if (!rst_n)
        begin
            count_q     <= 0;
            leader_q    <= '0;
            rotation_q  <= '0;
            policy_q    <= POL_LEADER;
            lag_limit_q <= '0;
            fail_count  <= 0;
            answers_q.delete();
        end
        else
        begin
            if (done)
            begin
                got = '{failed, to_leader, chosen_key, chosen_slot};
                if (answers_q.size() == 0)
                begin
                    fail_count = fail_count + 1;
                    if (fail_count <= 10)
                        $display("ERROR: result %h with no request waiting", got);
                end
                else
                begin
                    want = answers_q.pop_front();
                    if (got !== want)
                    begin
                        fail_count = fail_count + 1;
                        if (fail_count <= 10)
                            $display("ERROR: failed/to_leader/key/slot expected %b %b %h %h, got %b %b %h %h",
                                     want.failed, want.to_leader, want.key, want.slot,
                                     got.failed, got.to_leader, got.key, got.slot);
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_READ_POLICY)
                begin
                    policy_q   = cfg_data[1:0];
                    rotation_q = '0;
                end
                else if (cfg_index == CFG_MAX_READ_LAG)
                    lag_limit_q = cfg_data;
            end
            if (start && !busy)
                answers_q.push_back(apply_request(operation, node_key, link_up, is_streaming,
                                                  attached, replica_position, leader_position,
                                                  time_seconds));
        end
    end

endmodule

FILE: verif/tb.sv
// Testbench top for the replica read router: drives requests and config writes,
// and gives the verdict from the failure count of rrr_checker.
// Depends on rrr_pkg, replica_read_router_top and rrr_checker.
`timescale 1ns / 1ps

module tb;
    import rrr_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  operation;
    logic [15:0] node_key;
    logic        link_up;
    logic        is_streaming;
    logic        attached;
    logic [63:0] replica_position;
    logic [63:0] leader_position;
    logic [31:0] time_seconds;
    logic        done;
    logic        failed;
    logic        to_leader;
    logic [15:0] chosen_key;
    logic [3:0]  chosen_slot;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_index;
    logic [63:0] cfg_data;
    int          fail_count;
    int          pending;
    int          cycles;

    localparam int CYCLE_LIMIT = 2000000;

    replica_read_router_top dut (.*);
    rrr_checker checker_i (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic pause_random();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
        if (n > 0)
            start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // Holds one request until it is taken; start stays high until the caller
    // idles or chains the next request.
    task automatic send_request(logic [2:0] op, logic [15:0] key, logic lk, logic st,
                                logic at, logic [63:0] rpos, logic [63:0] lpos,
                                logic [31:0] tsec);
        operation        <= op;
        node_key         <= key;
        link_up          <= lk;
        is_streaming     <= st;
        attached         <= at;
        replica_position <= rpos;
        leader_position  <= lpos;
        time_seconds     <= tsec;
        start            <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (150) @(posedge clk);
    endtask

    task automatic write_register(logic [7:0] idx, logic [63:0] value);
        drain();
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Random request biased towards a small key pool so that the table fills
    // and most updates and removals hit real entries.
    task automatic random_request();
        logic [2:0]  op;
        logic [15:0] key;
        logic [63:0] rpos;
        logic [63:0] lpos;
        int          r;
        r = $urandom_range(0, 99);
        if (r < 35)      op = OP_ROUTE;
        else if (r < 55) op = OP_ADD;
        else if (r < 65) op = OP_REMOVE;
        else if (r < 88) op = OP_UPDATE;
        else if (r < 96) op = OP_LEADER;
        else             op = 3'($urandom_range(5, 7));
        key  = ($urandom_range(0, 9) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 19));
        rpos = ($urandom_range(0, 4) == 0) ? rand64() : 64'(1000 + $urandom_range(0, 400));
        lpos = ($urandom_range(0, 4) == 0) ? rand64() : 64'(1000 + $urandom_range(0, 400));
        send_request(op, key, $urandom_range(0, 5) != 0, $urandom_range(0, 5) != 0,
                     $urandom_range(0, 5) != 0, rpos, lpos, $urandom());
    endtask

    initial
    begin
        rst_n            = 1'b0;
        start            = 1'b0;
        operation        = OP_ROUTE;
        node_key         = '0;
        link_up          = 1'b0;
        is_streaming     = 1'b0;
        attached         = 1'b0;
        replica_position = '0;
        leader_position  = '0;
        time_seconds     = '0;
        cfg_valid        = 1'b0;
        cfg_index        = CFG_READ_POLICY;
        cfg_data         = '0;
        cycles           = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty table, fill to full, duplicate, extremes, every policy.
        send_request(OP_ROUTE, 16'h0, 1'b0, 1'b0, 1'b0, '0, '0, '1);
        send_request(OP_REMOVE, 16'hFFFF, 1'b0, 1'b0, 1'b0, '0, '0, '0);
        send_request(OP_UPDATE, 16'hFFFF, 1'b1, 1'b1, 1'b1, '1, '0, '0);
        for (int k = 0; k < 16; k++)
            send_request(OP_ADD, (k == 15) ? 16'hFFFF : 16'(k), 1'b0, 1'b0, 1'b0, '0, '0, '0);
        send_request(OP_ADD, 16'h1234, 1'b0, 1'b0, 1'b0, '0, '0, '0);
        send_request(OP_ADD, 16'h0003, 1'b0, 1'b0, 1'b0, '0, '0, '0);
        send_request(OP_UPDATE, 16'hFFFF, 1'b1, 1'b1, 1'b1, '1, '0, '0);
        send_request(OP_UPDATE, 16'h0002, 1'b1, 1'b1, 1'b1, '0, '0, '0);
        send_request(OP_LEADER, 16'h0, 1'b0, 1'b0, 1'b0, '0, '1, '0);
        send_request(OP_REMOVE, 16'h0000, 1'b0, 1'b0, 1'b0, '0, '0, '0);
        send_request(3'd7, 16'hFFFF, 1'b1, 1'b1, 1'b1, '1, '1, '1);
        send_request(OP_ROUTE, 16'h0, 1'b0, 1'b0, 1'b0, '0, '0, '1);

        for (int p = 0; p < 4; p++)
        begin
            write_register(CFG_READ_POLICY, 64'(p) | 64'hFFFF_FFFF_FFFF_FFFC);
            write_register(CFG_MAX_READ_LAG, (p == 2) ? 64'h1 : ((p == 3) ? '1 : '0));
            send_request(OP_ROUTE, 16'h0, 1'b0, 1'b0, 1'b0, '0, '0, '1);
            send_request(OP_ROUTE, 16'h0, 1'b0, 1'b0, 1'b0, '0, '0, '0);
        end
        // Clear the table so the random part starts from scratch.
        for (int k = 0; k < 16; k++)
            send_request(OP_REMOVE, (k == 15) ? 16'hFFFF : 16'(k), 1'b0, 1'b0, 1'b0, '0, '0, '0);

        for (int phase = 0; phase < 8; phase++)
        begin
            write_register(CFG_READ_POLICY, 64'(phase % 4));
            case ($urandom_range(0, 3))
                0: write_register(CFG_MAX_READ_LAG, '0);
                1: write_register(CFG_MAX_READ_LAG, '1);
                2: write_register(CFG_MAX_READ_LAG, 64'($urandom_range(1, 300)));
                default: write_register(CFG_MAX_READ_LAG, rand64());
            endcase
            for (int n = 0; n < 160; n++)
            begin
                if ($urandom_range(0, 2) != 0)
                    pause_random();
                random_request();
                if (n == 80)
                begin
                    start <= 1'b0;
                    @(posedge clk);
                    while (pending != 0)
                        @(posedge clk);
                end
            end
        end

        drain();
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: replica_read_router_top.f
rtl/core/rrr_pkg.sv
rtl/core/rrr_cell.sv
rtl/core/replica_read_router_top.sv
rtl/core/rrr_checker.sv
verif/rrr_checker.sv
verif/tb.sv
